@@ sv/fst_pkg.sv @@
package fst_pkg;

   localparam int MAX_STATES = 16;
   localparam int IDX_W      = $clog2(MAX_STATES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int PAIR_W     = 2 * IDX_W;
   localparam int MASK_W     = 16;

   typedef struct packed {
      logic [3:0] next_on_zero;
      logic [3:0] next_on_one;
      logic       out_on_zero;
      logic       out_on_one;
      logic       last_state;
   } req_type;

   typedef struct packed {
      logic [3:0]        state_index;
      logic [MASK_W-1:0] equivalent_mask;
      logic              last_result;
   } rsp_type;

   // one loaded state of the machine
   typedef struct packed {
      logic [3:0] next_on_zero;
      logic [3:0] next_on_one;
      logic       out_on_zero;
      logic       out_on_one;
   } trans_entry_type;

   localparam int TRANS_W = $bits(trans_entry_type);

endpackage

@@ sv/fst_ram.sv @@
module fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fsm_state_equivalence_table_unit.sv @@
// Mealy machine state equivalence by implication table. States are loaded one transaction
// per cycle (start high while busy is low); a transaction without last_state only stores
// its state. The transaction with last_state raises busy and starts the table build over
// the n stored states (states past the sixteenth are dropped, their last flag still
// counts). The initial output-compare pass seeds every state pair, each marking pass
// visits all n(n-1)/2 pairs, repeated until a pass marks nothing, and the report
// reads the pair bits of each state in turn. All steps go through the single read
// port of the pair table, which is consulted once per cycle. Results come out in state
// order, one per state, each shown with rsp_strobe high for exactly one cycle;
// the receiver cannot stall, so it must take every transaction as it appears. The last
// result carries last_result; busy drops with it and the next machine may then load.
module fsm_state_equivalence_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  fst_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output fst_pkg::rsp_type rsp_data
);

   import fst_pkg::*;

   // sequencer states
   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_INIT_RD = 4'd1;
   localparam logic [3:0] S_INIT_WR = 4'd2;
   localparam logic [3:0] S_MK_TR   = 4'd3;
   localparam logic [3:0] S_MK_CHK  = 4'd4;
   localparam logic [3:0] S_MK_P0   = 4'd5;
   localparam logic [3:0] S_MK_P1   = 4'd6;
   localparam logic [3:0] S_EM_RD   = 4'd7;
   localparam logic [3:0] S_EM_ACC  = 4'd8;
   localparam logic [3:0] S_EM_OUT  = 4'd9;

   // canonical table address of an unordered pair: smaller index in the upper half
   function automatic logic [PAIR_W-1:0] pair_addr(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
      if (a < b) begin
         pair_addr = {a, b};
      end else begin
         pair_addr = {b, a};
      end
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;   // states stored in the current load
   logic [CNT_W-1:0]  n_ff, n_in;           // states in the machine under work
   logic [CNT_W-1:0]  i_ff, i_in;           // row state
   logic [CNT_W-1:0]  j_ff, j_in;           // column state (also the mask bit in report)
   logic              changed_ff, changed_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   trans_entry_type   load_entry;
   logic              trans_wr_en;

   trans_entry_type   trans_i, trans_j;
   logic [TRANS_W-1:0] trans_i_raw, trans_j_raw;

   logic              dist_wr_en;
   logic [PAIR_W-1:0] dist_wr_addr;
   logic              dist_wr_data;
   logic [PAIR_W-1:0] dist_rd_addr;
   logic              dist_rd_data;

   logic              pass_end;
   logic [CNT_W-1:0]  i_step, j_step;
   logic              p0_ok, p1_ok;
   logic              outs_differ;

   // ---------------------------------------------------------------- storage

   assign accept     = start && !busy;
   assign load_entry = '{next_on_zero: req_data.next_on_zero,
                         next_on_one:  req_data.next_on_one,
                         out_on_zero:  req_data.out_on_zero,
                         out_on_one:   req_data.out_on_one};
   // drop states beyond the table capacity
   assign trans_wr_en = accept && (count_ff < CNT_W'(MAX_STATES));

   // two copies of the transition store, written together, read at rows i and j
   fst_ram #(.WIDTH(TRANS_W), .DEPTH(MAX_STATES)) u_trans_i (
      .clock   (clock),
      .wr_en   (trans_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (load_entry),
      .rd_addr (i_ff[IDX_W-1:0]),
      .rd_data (trans_i_raw)
   );

   fst_ram #(.WIDTH(TRANS_W), .DEPTH(MAX_STATES)) u_trans_j (
      .clock   (clock),
      .wr_en   (trans_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (load_entry),
      .rd_addr (j_ff[IDX_W-1:0]),
      .rd_data (trans_j_raw)
   );

   assign trans_i = trans_i_raw;
   assign trans_j = trans_j_raw;

   // implication table, one bit per unordered pair of states
   fst_ram #(.WIDTH(1), .DEPTH(MAX_STATES * MAX_STATES)) u_dist (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   // ---------------------------------------------------------------- pair walk

   // the walk covers i < j < n; the pass ends on the last pair
   assign pass_end = (i_ff == n_ff - CNT_W'(2)) && (j_ff == n_ff - CNT_W'(1));
   assign i_step   = (j_ff == n_ff - CNT_W'(1)) ? i_ff + CNT_W'(1) : i_ff;
   assign j_step   = (j_ff == n_ff - CNT_W'(1)) ? i_ff + CNT_W'(2) : j_ff + CNT_W'(1);

   assign outs_differ = (trans_i.out_on_zero != trans_j.out_on_zero) ||
                        (trans_i.out_on_one  != trans_j.out_on_one);

   // a successor pair only counts when both are loaded and they differ
   assign p0_ok = ({1'b0, trans_i.next_on_zero} < n_ff) &&
                  ({1'b0, trans_j.next_on_zero} < n_ff) &&
                  (trans_i.next_on_zero != trans_j.next_on_zero);
   assign p1_ok = ({1'b0, trans_i.next_on_one} < n_ff) &&
                  ({1'b0, trans_j.next_on_one} < n_ff) &&
                  (trans_i.next_on_one != trans_j.next_on_one);

   assign dist_wr_addr = pair_addr(i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]);

   // read address of the pair table follows the step of the sequencer
   always_comb begin
      unique case (state_ff)
         S_MK_CHK: dist_rd_addr = pair_addr(trans_i.next_on_zero, trans_j.next_on_zero);
         S_MK_P0:  dist_rd_addr = pair_addr(trans_i.next_on_one, trans_j.next_on_one);
         default:  dist_rd_addr = pair_addr(i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]);
      endcase
   end

   // ---------------------------------------------------------------- sequencer

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      changed_in    = changed_ff;
      mask_in       = mask_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      dist_wr_en    = 1'b0;
      dist_wr_data  = 1'b1;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (trans_wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_state) begin
                  n_in     = trans_wr_en ? count_ff + CNT_W'(1) : count_ff;
                  count_in = '0;
                  i_in     = '0;
                  j_in     = CNT_W'(1);
                  mask_in  = '0;
                  // a lone state has no pairs to compare
                  if (n_in < CNT_W'(2)) begin
                     j_in     = '0;
                     state_in = S_EM_RD;
                  end else begin
                     state_in = S_INIT_RD;
                  end
               end
            end
         end

         // wait for the transition rows of i and j
         S_INIT_RD: begin
            state_in = S_INIT_WR;
         end

         // seed the table from the outputs
         S_INIT_WR: begin
            dist_wr_en   = 1'b1;
            dist_wr_data = outs_differ;
            if (pass_end) begin
               i_in       = '0;
               j_in       = CNT_W'(1);
               changed_in = 1'b0;
               state_in   = S_MK_TR;
            end else begin
               i_in     = i_step;
               j_in     = j_step;
               state_in = S_INIT_RD;
            end
         end

         // transition rows and the pair bit (i,j) are in flight
         S_MK_TR: begin
            state_in = S_MK_CHK;
         end

         S_MK_CHK, S_MK_P0, S_MK_P1: begin
            priority if (state_ff == S_MK_CHK && !dist_rd_data) begin
               // unmarked pair: look at the successor pair under input 0
               state_in = S_MK_P0;
            end else if (state_ff == S_MK_P0 && !(p0_ok && dist_rd_data)) begin
               state_in = S_MK_P1;
            end else begin
               // already marked, or a successor pair is marked, or neither is
               if (state_ff == S_MK_P0 || (state_ff == S_MK_P1 && p1_ok && dist_rd_data)) begin
                  dist_wr_en = 1'b1;
                  changed_in = 1'b1;
               end
               if (pass_end) begin
                  i_in = '0;
                  if (changed_in) begin
                     j_in       = CNT_W'(1);
                     changed_in = 1'b0;
                     state_in   = S_MK_TR;
                  end else begin
                     j_in     = '0;
                     mask_in  = '0;
                     state_in = S_EM_RD;
                  end
               end else begin
                  i_in     = i_step;
                  j_in     = j_step;
                  state_in = S_MK_TR;
               end
            end
         end

         // report: read pair (i,k) for every loaded k
         S_EM_RD: begin
            state_in = S_EM_ACC;
         end

         S_EM_ACC: begin
            if (j_ff == i_ff) begin
               mask_in[j_ff[IDX_W-1:0]] = 1'b1;
            end else begin
               mask_in[j_ff[IDX_W-1:0]] = !dist_rd_data;
            end
            if (j_ff == n_ff - CNT_W'(1)) begin
               state_in = S_EM_OUT;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_EM_RD;
            end
         end

         S_EM_OUT: begin
            rsp_strobe_in          = 1'b1;
            rsp_in.state_index     = i_ff[IDX_W-1:0];
            rsp_in.equivalent_mask = mask_ff;
            rsp_in.last_result     = (i_ff == n_ff - CNT_W'(1));
            mask_in                = '0;
            j_in                   = '0;
            if (i_ff == n_ff - CNT_W'(1)) begin
               state_in = S_LOAD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_EM_RD;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         changed_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         changed_ff    <= changed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   // ---------------------------------------------------------------- ports

   assign busy       = (state_ff != S_LOAD);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fst_pkg::*;

   // how the expected results of a directed row are obtained
   typedef enum logic [1:0] {
      EXP_MODEL,   // worked out by the equivalence predictor
      EXP_APART,   // typed in: every state only equivalent to itself
      EXP_SAME     // typed in: every loaded state equivalent to every other
   } exp_kind_type;

   // one row of the directed stimulus table
   typedef struct {
      logic [3:0]   nxt0;
      logic [3:0]   nxt1;
      logic         out0;
      logic         out1;
      logic         last;
      exp_kind_type check;
   } dir_row_type;

   localparam int DIR_ROWS = 25;
   localparam int TOTAL_ITEMS = 230;
   localparam int MAX_MISMATCH_SHOW = 10;

   // dut ports
   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // travels with req_data so the acceptance monitor knows how to predict
   exp_kind_type row_check;

   // predictor state: the machine loaded so far
   trans_entry_type machine_rows [MAX_STATES];
   int              machine_count;
   logic [15:0]     apart_rows [MAX_STATES];

   // masks still owed by the block, oldest first
   rsp_type pending_masks [$];

   int fail_count;
   int mismatch_count;
   int items_sent;
   int burst_left;

   // directed table
   dir_row_type dir_rows [DIR_ROWS] = '{
      // single state machine, last flag on the first transaction
      '{4'd0,  4'd0,  1'b1, 1'b0, 1'b1, EXP_APART},
      // two states whose outputs differ
      '{4'd1,  4'd0,  1'b0, 1'b0, 1'b0, EXP_MODEL},
      '{4'd0,  4'd1,  1'b1, 1'b1, 1'b1, EXP_APART},
      // two equal-output states whose next states were never loaded
      '{4'd15, 4'd15, 1'b0, 1'b1, 1'b0, EXP_MODEL},
      '{4'd14, 4'd9,  1'b0, 1'b1, 1'b1, EXP_SAME},
      // marking propagates through input 0, input 1 leads both to the same state
      '{4'd1,  4'd2,  1'b0, 1'b0, 1'b0, EXP_MODEL},
      '{4'd2,  4'd2,  1'b0, 1'b0, 1'b0, EXP_MODEL},
      '{4'd2,  4'd2,  1'b1, 1'b0, 1'b1, EXP_MODEL},
      // sixteen states with equal outputs, next state extremes mixed in
      '{4'd0,  4'd15, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd15, 4'd0,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd15, 4'd15, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd0,  4'd0,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd5,  4'd10, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd10, 4'd5,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd3,  4'd12, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd12, 4'd3,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd7,  4'd8,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd8,  4'd7,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd1,  4'd14, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd14, 4'd1,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd6,  4'd9,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd9,  4'd6,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd11, 4'd4,  1'b1, 1'b1, 1'b0, EXP_MODEL},
      '{4'd4,  4'd11, 1'b1, 1'b1, 1'b0, EXP_MODEL},
      // seventeenth state is dropped, its different outputs must not count
      '{4'd15, 4'd15, 1'b0, 1'b0, 1'b1, EXP_SAME}
   };

   fsm_state_equivalence_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // pair is distinguishable; unloaded next states and self pairs never are
   function automatic bit pair_apart(input logic [3:0] a, input logic [3:0] b, input int n);
      if (int'(a) >= n || int'(b) >= n || a == b) return 1'b0;
      return apart_rows[a][b];
   endfunction

   // store one state, and on the last flag build the implication table and queue the masks
   task automatic predict_equivalence(input req_type item, input exp_kind_type check);
      int          n;
      bit          changed;
      logic [15:0] mask;
      rsp_type     res;
      if (machine_count < MAX_STATES) begin
         machine_rows[machine_count].next_on_zero = item.next_on_zero;
         machine_rows[machine_count].next_on_one  = item.next_on_one;
         machine_rows[machine_count].out_on_zero  = item.out_on_zero;
         machine_rows[machine_count].out_on_one   = item.out_on_one;
         machine_count++;
      end
      if (!item.last_state) return;

      n = machine_count;
      machine_count = 0;

      // output compare pass
      for (int i = 0; i < MAX_STATES; i++) apart_rows[i] = '0;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (machine_rows[i].out_on_zero != machine_rows[j].out_on_zero ||
                machine_rows[i].out_on_one != machine_rows[j].out_on_one)
               apart_rows[i][j] = 1'b1;
         end
      end

      // marking passes until nothing changes
      do begin
         changed = 1'b0;
         for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
               if (!apart_rows[i][j] &&
                   (pair_apart(machine_rows[i].next_on_zero, machine_rows[j].next_on_zero, n) ||
                    pair_apart(machine_rows[i].next_on_one, machine_rows[j].next_on_one, n))) begin
                  apart_rows[i][j] = 1'b1;
                  apart_rows[j][i] = 1'b1;
                  changed = 1'b1;
               end
            end
         end
      end while (changed);

      // one mask per stored state, in state order
      for (int i = 0; i < n; i++) begin
         case (check)
            EXP_APART: begin
               mask = 16'd1 << i;
            end
            EXP_SAME: begin
               mask = (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
            end
            default: begin
               mask = '0;
               for (int k = 0; k < n; k++)
                  if (!apart_rows[i][k]) mask[k] = 1'b1;
               mask[i] = 1'b1;
            end
         endcase
         res.state_index     = 4'(i);
         res.equivalent_mask = mask;
         res.last_result     = (i == n - 1);
         pending_masks = {pending_masks, res};
      end
   endtask

   // acceptance monitor: a transaction is taken when start is high and busy is low
   always @(posedge clock) begin
      if (!reset && start && !busy)
         predict_equivalence(req_data, row_check);
   end

   // result checker: every strobe must match the oldest pending mask
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_masks.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_MISMATCH_SHOW)
               $display("unexpected result: index %0d mask %04h last %0b",
                        rsp_data.state_index, rsp_data.equivalent_mask, rsp_data.last_result);
         end else begin
            want = pending_masks.pop_front();
            if (rsp_data.state_index !== want.state_index ||
                rsp_data.equivalent_mask !== want.equivalent_mask ||
                rsp_data.last_result !== want.last_result) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_MISMATCH_SHOW)
                  $display("mismatch: expected index %0d mask %04h last %0b,",
                           want.state_index, want.equivalent_mask, want.last_result,
                           " got index %0d mask %04h last %0b",
                           rsp_data.state_index, rsp_data.equivalent_mask, rsp_data.last_result);
            end
         end
      end
   end

   // present one transaction and hold it until the block takes it
   task automatic send_item(input req_type item, input exp_kind_type check);
      bit taken;
      req_data  <= item;
      row_check <= check;
      start     <= 1'b1;
      // busy only moves on rising edges, so the value at the falling edge decides
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // sender bursts: random burst lengths, random gaps, sometimes none
   task automatic sender_pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // one random machine, mostly well formed, sometimes pure noise
   task automatic send_random_machine();
      int          size;
      int          top;
      int          pick;
      bit          noise;
      logic [1:0]  outs_a;
      logic [1:0]  outs_b;
      logic [1:0]  outs;
      req_type     item;
      pick = $urandom_range(0, 9);
      if (pick < 7)      size = $urandom_range(1, 5);
      else if (pick < 9) size = $urandom_range(6, 10);
      else               size = $urandom_range(11, 19);
      top    = (size > MAX_STATES) ? MAX_STATES - 1 : size - 1;
      noise  = ($urandom_range(0, 9) == 0);
      // small palette of output pairs so that equivalent states show up often
      outs_a = 2'($urandom_range(0, 3));
      outs_b = 2'($urandom_range(0, 3));
      for (int s = 0; s < size; s++) begin
         if (noise) begin
            item.next_on_zero = 4'($urandom_range(0, 15));
            item.next_on_one  = 4'($urandom_range(0, 15));
            outs              = 2'($urandom_range(0, 3));
         end else begin
            item.next_on_zero = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(0, top));
            item.next_on_one  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(0, top));
            outs              = ($urandom_range(0, 3) == 0) ? outs_b : outs_a;
         end
         item.out_on_zero = outs[1];
         item.out_on_one  = outs[0];
         item.last_state  = (s == size - 1);
         send_item(item, EXP_MODEL);
         sender_pace();
      end
   endtask

   // main sequence
   initial begin
      req_type item;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      row_check      = EXP_MODEL;
      machine_count  = 0;
      fail_count     = 0;
      mismatch_count = 0;
      items_sent     = 0;
      burst_left     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         item.next_on_zero = dir_rows[r].nxt0;
         item.next_on_one  = dir_rows[r].nxt1;
         item.out_on_zero  = dir_rows[r].out0;
         item.out_on_one   = dir_rows[r].out1;
         item.last_state   = dir_rows[r].last;
         send_item(item, dir_rows[r].check);
         sender_pace();
      end

      // hold off until the block has drained
      start <= 1'b0;
      @(posedge clock);
      while (pending_masks.size() != 0) @(posedge clock);

      // random machines
      while (items_sent < TOTAL_ITEMS) send_random_machine();

      // drain, then watch for stray results
      start <= 1'b0;
      @(posedge clock);
      while (pending_masks.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (fail_count == 0 && pending_masks.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/fst_pkg.sv
sv/fst_ram.sv
sv/fsm_state_equivalence_table_unit.sv
test/tb_top.sv
